@@ rtl/lje_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_pkg: shared types and constants for the Lennard-Jones accumulator
// Transaction layouts, controller command and status bundles, operand codes.
// ----------------------------------------------------------------------------
package lje_pkg;

	localparam int POSITION_WIDTH             = 32;
	localparam int POSITION_FRACTION_BITS_DEF = 20;
	localparam int CUTOFF_WIDTH               = 32;
	localparam int ENERGY_WIDTH               = 64;
	localparam int LIMB_WIDTH                 = 32;
	localparam int RECIP_BITS                 = 81;

	localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = 32'd409600;
	localparam logic [ENERGY_WIDTH-1:0] TERM_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ENERGY_WIDTH-1:0] SUM_MIN      = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic signed [POSITION_WIDTH-1:0] first_x;
		logic signed [POSITION_WIDTH-1:0] first_y;
		logic signed [POSITION_WIDTH-1:0] first_z;
		logic signed [POSITION_WIDTH-1:0] second_x;
		logic signed [POSITION_WIDTH-1:0] second_y;
		logic signed [POSITION_WIDTH-1:0] second_z;
		logic signed [POSITION_WIDTH-1:0] offset_x;
		logic signed [POSITION_WIDTH-1:0] offset_y;
		logic signed [POSITION_WIDTH-1:0] offset_z;
		logic                             last_pair;
	} in_item_t;

	typedef struct packed {
		logic signed [ENERGY_WIDTH-1:0] energy_total;
		logic                           saturated;
	} out_item_t;

	typedef enum logic [3:0] {
		OPND_ZERO,
		OPND_DX_LO,
		OPND_DX_HI,
		OPND_DY_LO,
		OPND_DY_HI,
		OPND_DZ_LO,
		OPND_DZ_HI,
		OPND_R2,
		OPND_U2_LO,
		OPND_U2_HI,
		OPND_INV_LO,
		OPND_INV_HI
	} opnd_t;

	typedef enum logic [2:0] {
		LAT_NONE,
		LAT_R2,
		LAT_U2,
		LAT_DEN,
		LAT_INV12
	} lat_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		opnd_t      a_sel;
		opnd_t      b_sel;
		logic [1:0] shift;
		lat_t       lat;
		logic       div_step;
		logic       div_first;
		logic       term_en;
		logic       add_en;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic last;
	} sts_t;

endpackage

@@ rtl/lje_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_datapath: arithmetic for one atom pair
// Axis differences, shared 32x32 multiplier into a 128-bit accumulator,
// radix-2 reciprocal, term formation, saturating sum and result register.
// ----------------------------------------------------------------------------
module lje_datapath import lje_pkg::*; #(
	parameter int POSITION_FRACTION_BITS = POSITION_FRACTION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CUTOFF_WIDTH-1:0] cfg_data,
	input  in_item_t                in_data,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output out_item_t               out_data
);

	localparam int DW       = POSITION_WIDTH + 1;
	localparam int R2_SHIFT = 2 * POSITION_FRACTION_BITS - 16;
	localparam int ACC_W    = 4 * LIMB_WIDTH;
	localparam int DEN_W    = 3 * LIMB_WIDTH;
	localparam int WORD_W   = 2 * LIMB_WIDTH;

	function automatic logic [DW-1:0] axis_mag(
		input logic [POSITION_WIDTH-1:0] a,
		input logic [POSITION_WIDTH-1:0] b,
		input logic [POSITION_WIDTH-1:0] c
	);
		logic [POSITION_WIDTH+1:0] diff;
		diff = {{2{a[POSITION_WIDTH-1]}}, a} - {{2{b[POSITION_WIDTH-1]}}, b}
			- {{2{c[POSITION_WIDTH-1]}}, c};
		if (diff[POSITION_WIDTH+1]) begin
			diff = -diff;
		end
		return diff[DW-1:0];
	endfunction

	logic [CUTOFF_WIDTH-1:0] cutoff_q;
	logic [DW-1:0]           dx_q, dy_q, dz_q;
	logic                    last_q;
	logic [WORD_W-1:0]       prod_s1;
	logic [1:0]              shift_s1;
	logic                    prod_vld_s1;
	logic [ACC_W-1:0]        acc_q;
	logic [CUTOFF_WIDTH-1:0] r2_q;
	logic                    in_range_q;
	logic [WORD_W-1:0]       u2_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [RECIP_BITS-1:0]   q_q;
	logic [WORD_W-1:0]       inv12_q;
	logic                    p_ovf_q;
	logic [ENERGY_WIDTH-1:0] term_q;
	logic                    term_sat_q;
	logic [ENERGY_WIDTH-1:0] sum_q;
	logic                    sat_q;
	out_item_t               out_q;

	logic [WORD_W-1:0]       dx64, dy64, dz64, inv6;
	logic [LIMB_WIDTH-1:0]   mul_a, mul_b;
	logic [ACC_W-1:0]        addend, r2_wide;
	logic                    q_ovf;
	logic [DEN_W:0]          div_t, div_diff;
	logic                    div_ge;
	logic [WORD_W-1:0]       pos_diff, neg_diff, term_c;
	logic                    term_sat_c;
	logic [ENERGY_WIDTH-1:0] sum_c;
	logic                    sum_ovf;

	assign dx64  = WORD_W'(dx_q);
	assign dy64  = WORD_W'(dy_q);
	assign dz64  = WORD_W'(dz_q);
	assign inv6  = q_q[WORD_W-1:0];
	assign q_ovf = q_q[RECIP_BITS-1:WORD_W] != '0;

	function automatic logic [LIMB_WIDTH-1:0] pick(input opnd_t sel);
		logic [LIMB_WIDTH-1:0] v;
		case (sel)
			OPND_DX_LO:  v = dx64[LIMB_WIDTH-1:0];
			OPND_DX_HI:  v = dx64[WORD_W-1:LIMB_WIDTH];
			OPND_DY_LO:  v = dy64[LIMB_WIDTH-1:0];
			OPND_DY_HI:  v = dy64[WORD_W-1:LIMB_WIDTH];
			OPND_DZ_LO:  v = dz64[LIMB_WIDTH-1:0];
			OPND_DZ_HI:  v = dz64[WORD_W-1:LIMB_WIDTH];
			OPND_R2:     v = r2_q;
			OPND_U2_LO:  v = u2_q[LIMB_WIDTH-1:0];
			OPND_U2_HI:  v = u2_q[WORD_W-1:LIMB_WIDTH];
			OPND_INV_LO: v = inv6[LIMB_WIDTH-1:0];
			OPND_INV_HI: v = inv6[WORD_W-1:LIMB_WIDTH];
			default:     v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_a = pick(cmd.a_sel);
		mul_b = pick(cmd.b_sel);
	end

	always_comb begin
		case (shift_s1)
			2'd0:    addend = ACC_W'(prod_s1);
			2'd1:    addend = {{LIMB_WIDTH{1'b0}}, prod_s1, {LIMB_WIDTH{1'b0}}};
			2'd2:    addend = {prod_s1, {WORD_W{1'b0}}};
			default: addend = '0;
		endcase
	end

	assign r2_wide = acc_q >> R2_SHIFT;

	assign div_t    = {rem_q, cmd.div_first};
	assign div_diff = div_t - {1'b0, den_q};
	assign div_ge   = div_t >= {1'b0, den_q};

	always_comb begin
		pos_diff   = inv12_q - inv6;
		neg_diff   = inv6 - inv12_q;
		term_sat_c = 1'b0;
		term_c     = '0;
		if (q_ovf || p_ovf_q) begin
			term_sat_c = 1'b1;
			term_c     = TERM_MAX;
		end else if (inv12_q >= inv6) begin
			if (pos_diff[WORD_W-1:WORD_W-3] != '0) begin
				term_sat_c = 1'b1;
				term_c     = TERM_MAX;
			end else begin
				term_c = {pos_diff[WORD_W-3:0], 2'b00};
			end
		end else begin
			term_c = -{neg_diff[WORD_W-3:0], 2'b00};
		end
	end

	assign sum_c   = sum_q + term_q;
	assign sum_ovf = (sum_q[ENERGY_WIDTH-1] == term_q[ENERGY_WIDTH-1])
		&& (sum_c[ENERGY_WIDTH-1] != sum_q[ENERGY_WIDTH-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= CUTOFF_RESET;
			last_q      <= 1'b0;
			prod_vld_s1 <= 1'b0;
			in_range_q  <= 1'b0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				cutoff_q <= cfg_data;
			end
			prod_vld_s1 <= cmd.mul_en;
			if (cmd.load) begin
				last_q <= in_data.last_pair;
			end
			if (cmd.lat == LAT_R2) begin
				in_range_q <= (r2_wide[ACC_W-1:CUTOFF_WIDTH] == '0)
					&& (r2_wide[CUTOFF_WIDTH-1:0] <= cutoff_q);
			end
			if (cmd.add_en) begin
				sum_q <= sum_ovf ? (sum_q[ENERGY_WIDTH-1] ? SUM_MIN : TERM_MAX) : sum_c;
				sat_q <= sat_q | term_sat_q | sum_ovf;
			end
			if (cmd.emit) begin
				sum_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= axis_mag(in_data.first_x, in_data.second_x, in_data.offset_x);
			dy_q <= axis_mag(in_data.first_y, in_data.second_y, in_data.offset_y);
			dz_q <= axis_mag(in_data.first_z, in_data.second_z, in_data.offset_z);
		end
		prod_s1  <= WORD_W'(mul_a) * WORD_W'(mul_b);
		shift_s1 <= cmd.shift;
		if (cmd.load || cmd.lat != LAT_NONE) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + addend;
		end
		case (cmd.lat)
			LAT_R2:    r2_q <= r2_wide[CUTOFF_WIDTH-1:0];
			LAT_U2:    u2_q <= acc_q[WORD_W-1:0];
			LAT_DEN: begin
				den_q <= acc_q[DEN_W-1:0];
				rem_q <= '0;
				q_q   <= '0;
			end
			LAT_INV12: begin
				inv12_q <= acc_q[DEN_W-1:LIMB_WIDTH];
				p_ovf_q <= acc_q[ACC_W-1:DEN_W] != '0;
			end
			default: ;
		endcase
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
			q_q   <= {q_q[RECIP_BITS-2:0], div_ge};
		end
		if (cmd.term_en) begin
			term_q     <= term_c;
			term_sat_q <= term_sat_c;
		end
		if (cmd.emit) begin
			out_q.energy_total <= sum_q;
			out_q.saturated    <= sat_q;
		end
	end

	assign sts.in_range = in_range_q;
	assign sts.last     = last_q;
	assign out_data     = out_q;

	a_lat_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.lat != LAT_NONE) |-> !prod_vld_s1)
		else $error("accumulator latched while a product is still in flight");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!prod_vld_s1 && !cmd.mul_en))
		else $error("new pair loaded while the multiplier is busy");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (!prod_vld_s1 && !cmd.mul_en && !cmd.term_en))
		else $error("divider stepping alongside multiply or term work");

endmodule

@@ rtl/lje_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_ctrl: sequencer for the Lennard-Jones accumulator
// Steps the shared multiplier and divider through one pair and owns the
// input ready and the output valid.
// ----------------------------------------------------------------------------
module lje_ctrl import lje_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CNT_W     = $clog2(RECIP_BITS);
	localparam int SQR_MULS  = 12;
	localparam int U2_MULS   = 1;
	localparam int DEN_MULS  = 2;
	localparam int INV_MULS  = 4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQR,
		S_CHECK,
		S_U2,
		S_DEN,
		S_DIV,
		S_INV,
		S_TERM,
		S_ADD,
		S_FIN
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	function automatic opnd_t axis_limb(input logic [1:0] axis, input logic hi);
		opnd_t v;
		case (axis)
			2'd0:    v = hi ? OPND_DX_HI : OPND_DX_LO;
			2'd1:    v = hi ? OPND_DY_HI : OPND_DY_LO;
			2'd2:    v = hi ? OPND_DZ_HI : OPND_DZ_LO;
			default: v = OPND_ZERO;
		endcase
		return v;
	endfunction

	always_comb begin
		cmd       = '0;
		cmd.a_sel = OPND_ZERO;
		cmd.b_sel = OPND_ZERO;
		cmd.lat   = LAT_NONE;
		state_d   = state_q;
		cnt_d     = cnt_q + 1'b1;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQR;
				end
			end
			S_SQR: begin
				if (cnt_q < CNT_W'(SQR_MULS)) begin
					cmd.mul_en = 1'b1;
					cmd.a_sel  = axis_limb(cnt_q[3:2], cnt_q[1]);
					cmd.b_sel  = axis_limb(cnt_q[3:2], cnt_q[0]);
					cmd.shift  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
				end
				if (cnt_q == CNT_W'(SQR_MULS + 1)) begin
					cmd.lat = LAT_R2;
					state_d = S_CHECK;
					cnt_d   = '0;
				end
			end
			S_CHECK: begin
				cnt_d   = '0;
				state_d = sts.in_range ? S_U2 : S_FIN;
			end
			S_U2: begin
				if (cnt_q < CNT_W'(U2_MULS)) begin
					cmd.mul_en = 1'b1;
					cmd.a_sel  = OPND_R2;
					cmd.b_sel  = OPND_R2;
				end
				if (cnt_q == CNT_W'(U2_MULS + 1)) begin
					cmd.lat = LAT_U2;
					state_d = S_DEN;
					cnt_d   = '0;
				end
			end
			S_DEN: begin
				if (cnt_q < CNT_W'(DEN_MULS)) begin
					cmd.mul_en = 1'b1;
					cmd.a_sel  = cnt_q[0] ? OPND_U2_HI : OPND_U2_LO;
					cmd.b_sel  = OPND_R2;
					cmd.shift  = {1'b0, cnt_q[0]};
				end
				if (cnt_q == CNT_W'(DEN_MULS + 1)) begin
					cmd.lat = LAT_DEN;
					state_d = S_DIV;
					cnt_d   = '0;
				end
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = cnt_q == '0;
				if (cnt_q == CNT_W'(RECIP_BITS - 1)) begin
					state_d = S_INV;
					cnt_d   = '0;
				end
			end
			S_INV: begin
				if (cnt_q < CNT_W'(INV_MULS)) begin
					cmd.mul_en = 1'b1;
					cmd.a_sel  = cnt_q[1] ? OPND_INV_HI : OPND_INV_LO;
					cmd.b_sel  = cnt_q[0] ? OPND_INV_HI : OPND_INV_LO;
					cmd.shift  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
				end
				if (cnt_q == CNT_W'(INV_MULS + 1)) begin
					cmd.lat = LAT_INV12;
					state_d = S_TERM;
					cnt_d   = '0;
				end
			end
			S_TERM: begin
				cnt_d       = '0;
				cmd.term_en = 1'b1;
				state_d     = S_ADD;
			end
			S_ADD: begin
				cnt_d      = '0;
				cmd.add_en = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				cnt_d = '0;
				if (!sts.last) begin
					state_d = S_IDLE;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				cnt_d   = '0;
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second pair taken while one is in progress");

	a_drop_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without a transaction");

endmodule

@@ rtl/lennard_jones_energy_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_energy_accumulator_unit: 12-6 pair energy sum with cutoff
// Feed one atom pair per input transaction; the reduced 12-6 term of pairs
// inside the cutoff is summed with saturation. A pair marked last_pair
// releases the total on the output channel and clears the sum and flag.
//
// Channels: in_valid/in_ready/in_data (one pair), out_valid/out_ready/
// out_data (one total), cfg_valid/cfg_ready/cfg_data (squared cutoff,
// always ready; write only while no pair is in progress).
// A pair inside the cutoff runs through the 81-step radix-2 reciprocal
// and the single 32x32 multiplier, stepped over the limb products; a
// pair outside it ends after the squared-distance check. One pair is
// worked on at a time: in_ready is high only while the block is idle.
// Reset clears the sum, the flag and the output valid, and restores the
// cutoff to 6.25. A total waits in the output register while out_ready is
// low; the next pair is still taken, and a further last pair holds until
// the waiting total has gone.
// ----------------------------------------------------------------------------
module lennard_jones_energy_accumulator_unit import lje_pkg::*; #(
	parameter int POSITION_FRACTION_BITS = POSITION_FRACTION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CUTOFF_WIDTH-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_item_t               out_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lje_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lje_datapath #(
		.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lennard_jones_energy_accumulator_unit
// Drives atom pairs, cutoff writes and output back-pressure with random gaps.
// A fixed-point energy tracker predicts every emitted total and its flag, and
// each output transaction is checked against the oldest predicted total.
// ----------------------------------------------------------------------------
module tb import lje_pkg::*; ();

	localparam int SETTLE_CYCLES = 150;
	localparam int RANDOM_PER_PHASE = 220;
	localparam int SCALE_SHIFT = 2 * POSITION_FRACTION_BITS_DEF - 16;

	class lj_energy_tracker;
		logic [CUTOFF_WIDTH-1:0] cutoff;
		logic [ENERGY_WIDTH-1:0] energy_sum;
		logic saturation_seen;
		out_item_t totals_due[$];
		int mismatches;

		function new();
			cutoff = CUTOFF_RESET;
			energy_sum = '0;
			saturation_seen = 1'b0;
			mismatches = 0;
		endfunction

		function logic [63:0] axis_span(logic [31:0] a, logic [31:0] b, logic [31:0] c);
			logic [63:0] d;
			d = {{32{a[31]}}, a} - {{32{b[31]}}, b} - {{32{c[31]}}, c};
			return d[63] ? 64'd0 - d : d;
		endfunction

		function void take_pair(in_item_t p);
			logic [63:0] dx, dy, dz, inv6, inv12, term, total;
			logic [127:0] acc, den, quot, prod;
			logic [31:0] r2;
			logic sat;
			out_item_t done;
			dx = axis_span(p.first_x, p.second_x, p.offset_x);
			dy = axis_span(p.first_y, p.second_y, p.offset_y);
			dz = axis_span(p.first_z, p.second_z, p.offset_z);
			acc = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
			acc = acc >> SCALE_SHIFT;
			if (acc[127:32] == '0 && acc[31:0] <= cutoff) begin
				r2 = acc[31:0];
				sat = 1'b1;
				term = TERM_MAX;
				if (r2 != '0) begin
					den = 128'(r2) * 128'(r2) * 128'(r2);
					quot = (128'd1 << 80) / den;
					inv6 = quot[63:0];
					prod = (128'(inv6) * 128'(inv6)) >> 32;
					inv12 = prod[63:0];
					if (quot[127:64] == '0 && prod[127:64] == '0) begin
						if (inv12 >= inv6) begin
							if ((inv12 - inv6) <= (TERM_MAX >> 2)) begin
								sat = 1'b0;
								term = (inv12 - inv6) << 2;
							end
						end else begin
							sat = 1'b0;
							term = 64'd0 - ((inv6 - inv12) << 2);
						end
					end
				end
				total = energy_sum + term;
				if (energy_sum[63] == term[63] && total[63] != energy_sum[63]) begin
					total = energy_sum[63] ? SUM_MIN : TERM_MAX;
					sat = 1'b1;
				end
				energy_sum = total;
				saturation_seen = saturation_seen | sat;
			end
			if (p.last_pair) begin
				done.energy_total = energy_sum;
				done.saturated = saturation_seen;
				totals_due = {totals_due, done};
				energy_sum = '0;
				saturation_seen = 1'b0;
			end
		endfunction

		function int pending();
			return totals_due.size();
		endfunction

		function void check_total(out_item_t got);
			out_item_t want;
			if (totals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected total %h sat %b", got.energy_total, got.saturated);
			end else begin
				want = totals_due.pop_front();
				if (got.energy_total !== want.energy_total || got.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("total mismatch: expected %h sat %b, got %h sat %b",
							want.energy_total, want.saturated, got.energy_total, got.saturated);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CUTOFF_WIDTH-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	lj_energy_tracker sb;

	lennard_jones_energy_accumulator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 120);
	endfunction

	function automatic in_item_t separated_pair(int dx, int dy, int dz, logic last);
		in_item_t p;
		int base [3];
		int shift [3];
		logic same_cell;
		same_cell = 1'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++) begin
			base[i] = int'($urandom) >>> 3;
			shift[i] = same_cell ? 0 : int'($urandom) >>> 7;
		end
		p.first_x = base[0];
		p.first_y = base[1];
		p.first_z = base[2];
		p.offset_x = shift[0];
		p.offset_y = shift[1];
		p.offset_z = shift[2];
		p.second_x = base[0] - shift[0] - dx;
		p.second_y = base[1] - shift[1] - dy;
		p.second_z = base[2] - shift[2] - dz;
		p.last_pair = last;
		return p;
	endfunction

	function automatic in_item_t uniform_pair(logic [31:0] f, logic [31:0] s, logic [31:0] o);
		in_item_t p;
		p.first_x = f;
		p.first_y = f;
		p.first_z = f;
		p.second_x = s;
		p.second_y = s;
		p.second_z = s;
		p.offset_x = o;
		p.offset_y = o;
		p.offset_z = o;
		p.last_pair = 1'b1;
		return p;
	endfunction

	function automatic int rand_delta();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return int'($urandom_range(0, 6 * 1048576)) - 3 * 1048576;
		if (sel < 8)
			return int'($urandom_range(0, 1 << 19)) - (1 << 18);
		if (sel == 8)
			return int'($urandom_range(0, 1 << 29)) - (1 << 28);
		return int'($urandom_range(0, 8192)) - 4096;
	endfunction

	function automatic in_item_t rand_pair(logic last);
		in_item_t p;
		if ($urandom_range(0, 9) == 0) begin
			p.first_x = $urandom;
			p.first_y = $urandom;
			p.first_z = $urandom;
			p.second_x = $urandom;
			p.second_y = $urandom;
			p.second_z = $urandom;
			p.offset_x = $urandom;
			p.offset_y = $urandom;
			p.offset_z = $urandom;
			p.last_pair = last;
			return p;
		end
		return separated_pair(rand_delta(), rand_delta(), rand_delta(), last);
	endfunction

	task automatic send_pair(input in_item_t p);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_pair(p);
	endtask

	task automatic rest_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain();
		rest_sender(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_cutoff(input logic [CUTOFF_WIDTH-1:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.cutoff = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int grp;
		grp = 0;
		for (int left = count; left > 0; left--) begin
			if (grp == 0)
				grp = $urandom_range(1, 6);
			send_pair(rand_pair(grp == 1));
			grp--;
			rest_sender(gap_len());
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_total(out_data);
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			repeat (gap_len()) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			repeat ($urandom_range(1, 40)) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#4000000;
		$display("FAIL lennard_jones_energy_accumulator_unit");
		$finish;
	end

	initial begin
		logic [CUTOFF_WIDTH-1:0] plan [5];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// zero distance, cutoff edge, term overflow, well and repulsive wall
		send_pair(separated_pair(0, 0, 0, 1'b1));
		send_pair(separated_pair(2621440, 0, 0, 1'b1));
		send_pair(separated_pair(0, 2621444, 0, 1'b1));
		send_pair(separated_pair(0, 0, 16384, 1'b1));
		send_pair(separated_pair(52429, 0, 0, 1'b1));
		send_pair(separated_pair(1048576, 0, 0, 1'b1));
		send_pair(separated_pair(-680000, 680000, -680000, 1'b1));
		send_pair(separated_pair(943718, 0, 0, 1'b1));
		// accumulate over a group
		send_pair(separated_pair(1200000, 300000, 0, 1'b0));
		send_pair(separated_pair(0, -1500000, 400000, 1'b0));
		send_pair(separated_pair(2000000, 0, 0, 1'b1));
		// drive the sum into its positive limit
		send_pair(separated_pair(0, 0, 0, 1'b0));
		send_pair(separated_pair(0, 0, 0, 1'b0));
		send_pair(separated_pair(0, 0, 0, 1'b1));
		// field extremes
		send_pair(uniform_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_pair(uniform_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_pair(uniform_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
		send_pair(uniform_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_pair(uniform_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
		send_pair(uniform_pair(32'h8000_0000, 32'h8000_0000, 32'h0));
		rest_sender(1);
		run_random(RANDOM_PER_PHASE);

		plan[0] = 32'hFFFF_FFFF;
		plan[1] = 32'h0;
		plan[2] = $urandom_range(65536, 2000000);
		plan[3] = CUTOFF_RESET;
		plan[4] = $urandom;
		for (int k = 0; k < 5; k++) begin
			write_cutoff(plan[k]);
			// squared distance just inside and just beyond 32 bits
			send_pair(separated_pair(268435455, 0, 0, 1'b1));
			send_pair(separated_pair(0, 0, 268435456, 1'b1));
			run_random(RANDOM_PER_PHASE);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS lennard_jones_energy_accumulator_unit");
		else
			$display("FAIL lennard_jones_energy_accumulator_unit");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lje_pkg.sv
rtl/lje_datapath.sv
rtl/lje_ctrl.sv
rtl/lennard_jones_energy_accumulator_unit.sv
tb/tb.sv
